[rtl/core/irb_pkg.sv]
// ----------------------------------------------------------------------------
// irb_pkg
// Types, codes and constants shared by the indexed bitmap blit core.
// ----------------------------------------------------------------------------
package irb_pkg;

  localparam int ADDR_W     = 24;
  localparam int DIM_W      = 11;
  localparam int HEIGHT_W   = 12;
  localparam int PITCH_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PAL_DEPTH  = 16;
  localparam int PAL_IDX_W  = 4;
  localparam int USED_W     = 5;
  localparam int BPP_W      = 6;

  localparam logic [1:0] FUNC_BEGIN   = 2'd0;
  localparam logic [1:0] FUNC_PALETTE = 2'd1;
  localparam logic [1:0] FUNC_PIXEL   = 2'd2;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_PITCH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_PITCH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 3'd4;

  localparam logic [BPP_W-1:0] SUPPORTED_BPP = 6'd4;

  typedef struct packed {
    logic [1:0]                 func;
    logic [DIM_W-1:0]           image_width;
    logic signed [HEIGHT_W-1:0] image_height;
    logic [BPP_W-1:0]           bits_per_pixel;
    logic [15:0]                color_count;
    logic [PAL_IDX_W-1:0]       entry_index;
    logic [7:0]                 red;
    logic [7:0]                 green;
    logic [7:0]                 blue;
    logic [7:0]                 pixel_pair;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [15:0]       color;
    logic              last;
  } result_t;

  function automatic logic [15:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    rgb565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

[rtl/core/irb_stream_if.sv]
// ----------------------------------------------------------------------------
// irb_stream_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface irb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/irb_addr_unit.sv]
// ----------------------------------------------------------------------------
// irb_addr_unit
// Computes base + a * p + b * q modulo the address width, with a and b
// unsigned counts and p and q signed byte pitches.
// ----------------------------------------------------------------------------
module irb_addr_unit
  import irb_pkg::*;
(
  input  logic [ADDR_W-1:0]         base,
  input  logic [DIM_W-1:0]          a,
  input  logic signed [PITCH_W-1:0] p,
  input  logic [DIM_W-1:0]          b,
  input  logic signed [PITCH_W-1:0] q,
  output logic [ADDR_W-1:0]         addr
);

  localparam int PROD_W = DIM_W + 1 + PITCH_W;

  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic signed [PROD_W:0]   offset;

  assign prod_a = $signed({1'b0, a}) * p;
  assign prod_b = $signed({1'b0, b}) * q;
  assign offset = {prod_a[PROD_W-1], prod_a} + {prod_b[PROD_W-1], prod_b};
  assign addr   = base + offset[ADDR_W-1:0];

endmodule

[rtl/core/indexed_bitmap_to_rgb565_blit_core.sv]
// ----------------------------------------------------------------------------
// indexed_bitmap_to_rgb565_blit_core
// Blits a 4-bit palette image, centered, into an RGB565 framebuffer region.
// ----------------------------------------------------------------------------
// Items arrive on the item channel: a begin beat checks the image against the
// region, clears the palette and answers accepted or rejected; palette beats
// load 565 colors and give no result; pixel beats give two pixel writes, left
// pixel first, one if an odd-width row ends on high nibble, none if no image.
// Results leave on the result channel, one beat per cycle while the receiver
// is ready, the final beat of an item marked by last. Region geometry is
// written over the wr_* port. An accepted item sits in the input register
// until it has made its last result, or been stepped if it makes none;
// its first result passes from the input register through the result
// register. A new item is taken as the held one finishes.
// Every pixel address comes from one combinational multiply-add unit, which
// evaluates origin + column * x_pitch + drow * y_pitch (drow flips bottom-up).
// Reset loads the register defaults, clears the palette and drops any image.
// When the receiver stalls, the result register holds its beat and the input
// register holds its item; the item channel takes no beats until the held
// item has finished.
// ----------------------------------------------------------------------------
module indexed_bitmap_to_rgb565_blit_core
  import irb_pkg::*;
#(
  parameter int MAX_DIM = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  irb_stream_if.sink            item,
  irb_stream_if.source          result,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  logic [DIM_W-1:0]          area_width;
  logic [DIM_W-1:0]          area_height;
  logic signed [PITCH_W-1:0] x_pitch;
  logic signed [PITCH_W-1:0] y_pitch;
  logic [ADDR_W-1:0]         base_offset;

  logic [15:0]          palette [PAL_DEPTH];
  logic [USED_W-1:0]    entries_used;
  logic [DIM_W-1:0]     img_width_reg;
  logic [DIM_W-1:0]     img_height_reg;
  logic                 bottom_up;
  logic [DIM_W-1:0]     column;
  logic [DIM_W-1:0]     row;
  logic [ADDR_W-1:0]    origin_address;
  logic                 active;

  logic                 held;
  item_t                held_item;
  logic                 phase;

  logic                 out_valid;
  result_t              out_data;

  logic                 out_free;
  logic                 step;
  logic                 done;
  logic                 emit;
  logic                 is_begin;
  logic                 is_palette;
  logic                 is_pixel;
  logic [HEIGHT_W-1:0]  h_mag;
  logic                 bad_image;
  logic [DIM_W-1:0]     half_x;
  logic [DIM_W-1:0]     half_y;
  logic [DIM_W-1:0]     drow;
  logic [DIM_W-1:0]     column_next;
  logic [DIM_W-1:0]     row_next;
  logic                 row_end;
  logic [PAL_IDX_W-1:0] nibble;
  logic [ADDR_W-1:0]    unit_base;
  logic [DIM_W-1:0]     unit_a;
  logic [DIM_W-1:0]     unit_b;
  logic [ADDR_W-1:0]    unit_addr;
  result_t              out_next;

  assign out_free   = !out_valid || result.ready;
  assign step       = held && out_free;
  assign is_begin   = (held_item.func == FUNC_BEGIN);
  assign is_palette = (held_item.func == FUNC_PALETTE);
  assign is_pixel   = (held_item.func == FUNC_PIXEL);

  assign h_mag = held_item.image_height[HEIGHT_W-1] ? HEIGHT_W'(-held_item.image_height)
                                                   : HEIGHT_W'(held_item.image_height);
  assign bad_image = (held_item.bits_per_pixel != SUPPORTED_BPP) ||
                     (held_item.image_width > area_width) ||
                     (h_mag > {1'b0, area_height}) ||
                     (32'(held_item.image_width) > 32'(MAX_DIM)) ||
                     (32'(h_mag) > 32'(MAX_DIM));
  assign half_x = (area_width - held_item.image_width) >> 1;
  assign half_y = (area_height - h_mag[DIM_W-1:0]) >> 1;

  assign drow        = bottom_up ? (img_height_reg - DIM_W'(1) - row) : row;
  assign column_next = column + DIM_W'(1);
  assign row_next    = row + DIM_W'(1);
  assign row_end     = (column_next >= img_width_reg);
  assign nibble      = phase ? held_item.pixel_pair[3:0] : held_item.pixel_pair[7:4];

  assign unit_base = is_begin ? base_offset : origin_address;
  assign unit_a    = is_begin ? half_x : column;
  assign unit_b    = is_begin ? half_y : drow;

  irb_addr_unit u_addr (
    .base (unit_base),
    .a    (unit_a),
    .p    (x_pitch),
    .b    (unit_b),
    .q    (y_pitch),
    .addr (unit_addr)
  );

  always_comb begin
    done = 1'b1;
    if (is_pixel && active && !phase && !row_end) begin
      done = 1'b0;
    end
  end

  assign emit       = step && (is_begin || (is_pixel && active));
  assign item.ready = !held || (step && done);

  always_comb begin
    out_next = '0;
    if (is_begin) begin
      out_next.kind = bad_image ? KIND_REJECT : KIND_ACCEPT;
      out_next.last = 1'b1;
    end else begin
      out_next.kind    = KIND_PIXEL;
      out_next.address = unit_addr;
      out_next.color   = palette[nibble];
      out_next.last    = phase || row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= DIM_W'(640);
      area_height <= DIM_W'(400);
      x_pitch     <= PITCH_W'(2);
      y_pitch     <= PITCH_W'(1280);
      base_offset <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_AREA_WIDTH:  area_width  <= wr_data[DIM_W-1:0];
        REG_AREA_HEIGHT: area_height <= wr_data[DIM_W-1:0];
        REG_X_PITCH:     x_pitch     <= wr_data[PITCH_W-1:0];
        REG_Y_PITCH:     y_pitch     <= wr_data[PITCH_W-1:0];
        REG_BASE_OFFSET: base_offset <= wr_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      phase <= 1'b0;
    end else if (item.valid && item.ready) begin
      held  <= 1'b1;
      phase <= 1'b0;
    end else if (step && done) begin
      held  <= 1'b0;
      phase <= 1'b0;
    end else if (step) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held_item <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAL_DEPTH; i++) begin
        palette[i] <= '0;
      end
      entries_used   <= '0;
      img_width_reg  <= '0;
      img_height_reg <= '0;
      bottom_up      <= 1'b0;
      column         <= '0;
      row            <= '0;
      origin_address <= '0;
      active         <= 1'b0;
    end else if (step) begin
      if (is_begin) begin
        for (int i = 0; i < PAL_DEPTH; i++) begin
          palette[i] <= '0;
        end
        entries_used <= (held_item.color_count < 16'(PAL_DEPTH))
                        ? held_item.color_count[USED_W-1:0] : USED_W'(PAL_DEPTH);
        column <= '0;
        row    <= '0;
        active <= 1'b0;
        if (!bad_image) begin
          img_width_reg  <= held_item.image_width;
          img_height_reg <= h_mag[DIM_W-1:0];
          bottom_up      <= !held_item.image_height[HEIGHT_W-1] &&
                            (held_item.image_height != '0);
          origin_address <= unit_addr;
          active         <= (held_item.image_width != '0) && (h_mag != '0);
        end
      end else if (is_palette) begin
        if ({1'b0, held_item.entry_index} < entries_used) begin
          palette[held_item.entry_index] <= rgb565(held_item.red, held_item.green,
                                                   held_item.blue);
        end
      end else if (is_pixel && active) begin
        if (row_end) begin
          column <= '0;
          row    <= row_next;
          if (row_next >= img_height_reg) begin
            active <= 1'b0;
          end
        end else begin
          column <= column_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= out_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule
